>>> rtl/gpio_pkg.sv
// shared types, register offsets and identification bytes for the gpio port
`default_nettype none

package gpio_pkg;

    localparam int PinCountDefault = 8;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // register word offsets (byte address / 4)
    localparam logic [9:0] OFS_DATA_FIRST = 10'h000;
    localparam logic [9:0] OFS_DATA_LAST  = 10'h0ff;
    localparam logic [9:0] OFS_DIR        = 10'h100;
    localparam logic [9:0] OFS_IS         = 10'h101;
    localparam logic [9:0] OFS_IBE        = 10'h102;
    localparam logic [9:0] OFS_IEV        = 10'h103;
    localparam logic [9:0] OFS_IE         = 10'h104;
    localparam logic [9:0] OFS_RIS        = 10'h105;
    localparam logic [9:0] OFS_MIS        = 10'h106;
    localparam logic [9:0] OFS_IC         = 10'h107;
    localparam logic [9:0] OFS_AFSEL      = 10'h108;
    localparam logic [9:0] OFS_ID_FIRST   = 10'h3f8;
    localparam logic [9:0] OFS_ID_LAST    = 10'h3ff;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] word_offset;
        logic [7:0] write_data;
        logic [2:0] line_index;
        logic       line_level;
    } gpio_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
    } gpio_rsp_t;

    function automatic logic [7:0] id_byte(input logic [2:0] sel);
        logic [7:0] b;
        case (sel)
            3'd0:    b = 8'h61;
            3'd1:    b = 8'h10;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'hf0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hb1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gpio_port_with_interrupts.sv
// gpio port top level: request channel, register file and buffered response
//
// Usage: each request transaction is a bus read, a bus write or a level
// change on one external pin. Every request gives exactly one response
// transaction carrying the read data (zero unless a read hits a readable
// register) and the interrupt level after the request has taken effect.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// Each response is registered in the response register or the skid register.
// Throughput: one request per cycle while req_stall is low; register state updates
// in the same edge that takes the request, so back-to-back requests see each other.
// Stall: a two-entry output buffer (response register plus skid register)
// keeps the request side open for one more transaction while the receiver
// stalls; req_stall rises only when the skid register is occupied.
// Reset: all gpio registers clear to zero (all pins inputs, no interrupt
// status, interrupts disabled) and both response entries are emptied.
`default_nettype none

module gpio_port_with_interrupts
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = PinCountDefault
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire gpio_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output gpio_rsp_t      rsp
);

    gpio_rsp_t result;
    gpio_rsp_t head_reg, head_next;
    gpio_rsp_t skid_reg, skid_next;
    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      push;
    logic      pop;

    assign req_stall = skid_valid_reg;
    assign push      = req_valid && !req_stall;
    assign pop       = head_valid_reg && !rsp_stall;

    gpio_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (push),
        .req   (req),
        .rsp   (result)
    );

    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !head_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = result;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = head_valid_reg;
    assign rsp       = head_reg;

`ifndef SYNTHESIS
    // skid entry is never occupied while the response register is empty
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty response register");

    // a transaction taken while the receiver stalls a full head lands in the skid entry
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && head_valid_reg && rsp_stall) |=> skid_valid_reg)
        else $error("request lost while response stalled");

    // last response taken with nothing behind it empties the buffer
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !rsp_valid)
        else $error("response repeated after drain");

    // every transaction taken into an idle buffer is offered next cycle
    a_offer: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !head_valid_reg) |=> rsp_valid)
        else $error("response missing after request");
`endif

endmodule

`default_nettype wire

>>> rtl/gpio_regs.sv
// gpio register file: bus decode, pin change capture and interrupt status
`default_nettype none

module gpio_regs
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = PinCountDefault
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire gpio_req_t req,
    output gpio_rsp_t      rsp
);

    localparam logic [7:0] PinMask = 8'((16'd1 << PIN_COUNT) - 16'd1);
    localparam logic [3:0] PinLimit = 4'(PIN_COUNT);

    logic [7:0] data_reg, data_next;
    logic [7:0] dir_reg, dir_next;
    logic [7:0] sense_reg, sense_next;
    logic [7:0] ibe_reg, ibe_next;
    logic [7:0] iev_reg, iev_next;
    logic [7:0] ie_reg, ie_next;
    logic [7:0] raw_reg, raw_next;
    logic [7:0] afsel_reg, afsel_next;

    logic [7:0] wv;
    logic [7:0] mask;
    logic [7:0] pin_bit;
    logic [7:0] raw_edge;
    logic [7:0] rd;
    logic       pin_ok;

    assign wv      = req.write_data & PinMask;
    assign mask    = req.word_offset[7:0];
    assign pin_bit = 8'd1 << req.line_index;
    // pin exists, is an input and really changes level
    assign pin_ok  = ({1'b0, req.line_index} < PinLimit)
                     && ((|(data_reg & pin_bit)) != req.line_level)
                     && !(|(dir_reg & pin_bit));

    always_comb
    begin
        data_next  = data_reg;
        dir_next   = dir_reg;
        sense_next = sense_reg;
        ibe_next   = ibe_reg;
        iev_next   = iev_reg;
        ie_next    = ie_reg;
        raw_next   = raw_reg;
        afsel_next = afsel_reg;
        raw_edge   = raw_reg;
        rd         = 8'h00;
        case (req.cmd)
            CMD_READ:
            begin
                case (req.word_offset) inside
                    [OFS_DATA_FIRST:OFS_DATA_LAST]: rd = data_reg & mask;
                    [OFS_ID_FIRST:OFS_ID_LAST]:     rd = id_byte(req.word_offset[2:0]);
                    OFS_DIR:                        rd = dir_reg;
                    OFS_IS:                         rd = sense_reg;
                    OFS_IBE:                        rd = ibe_reg;
                    OFS_IEV:                        rd = iev_reg;
                    OFS_IE:                         rd = ie_reg;
                    OFS_RIS:                        rd = raw_reg;
                    OFS_MIS:                        rd = raw_reg & ie_reg;
                    OFS_AFSEL:                      rd = afsel_reg;
                    default:                        rd = 8'h00;
                endcase
            end
            CMD_WRITE:
            begin
                case (req.word_offset) inside
                    // masked data write, input pins read back as zero afterwards
                    [OFS_DATA_FIRST:OFS_DATA_LAST]:
                        data_next = ((wv & mask) | (data_reg & ~mask)) & dir_reg & PinMask;
                    OFS_DIR:   dir_next   = wv;
                    OFS_IS:    sense_next = wv;
                    OFS_IBE:   ibe_next   = wv;
                    OFS_IEV:   iev_next   = wv;
                    OFS_IE:    ie_next    = wv;
                    OFS_IC:    raw_next   = raw_reg & ~wv;
                    OFS_AFSEL: afsel_next = wv;
                    default:   ;
                endcase
            end
            CMD_PIN:
            begin
                if (pin_ok)
                begin
                    data_next = req.line_level ? (data_reg | pin_bit) : (data_reg & ~pin_bit);
                    if (|(~sense_reg & pin_bit))
                        raw_edge = raw_reg | (pin_bit & ibe_reg);
                    // level capture looks at every high level pin, not only this one
                    raw_next = raw_edge | (sense_reg & data_next & iev_reg);
                end
            end
            default: ;
        endcase
    end

    assign rsp.read_data = rd;
    assign rsp.irq_level = |(raw_next & ie_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg  <= 8'h00;
            dir_reg   <= 8'h00;
            sense_reg <= 8'h00;
            ibe_reg   <= 8'h00;
            iev_reg   <= 8'h00;
            ie_reg    <= 8'h00;
            raw_reg   <= 8'h00;
            afsel_reg <= 8'h00;
        end
        else if (en)
        begin
            data_reg  <= data_next;
            dir_reg   <= dir_next;
            sense_reg <= sense_next;
            ibe_reg   <= ibe_next;
            iev_reg   <= iev_next;
            ie_reg    <= ie_next;
            raw_reg   <= raw_next;
            afsel_reg <= afsel_next;
        end
    end

endmodule

`default_nettype wire
